// File: rtl/ptsd_pkg.sv
// Shared types and constants for the point-to-segment distance block.
package ptsd_pkg;

    // Coordinate width in bits, two's complement Q16.16.
    localparam int COORD_BITS = 32;
    localparam int DIST_BITS  = COORD_BITS + 1;
    localparam int CFG_IDX_BITS = 3;

    // Where the nearest point lies on the segment.
    typedef enum logic [1:0] {
        WHERE_INTERIOR = 2'd0,
        WHERE_END_A    = 2'd1,
        WHERE_END_B    = 2'd2,
        WHERE_DEGEN    = 2'd3
    } where_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_END_A_X = 3'd0,
        CFG_END_A_Y = 3'd1,
        CFG_END_A_Z = 3'd2,
        CFG_END_B_X = 3'd3,
        CFG_END_B_Y = 3'd4,
        CFG_END_B_Z = 3'd5
    } cfg_idx_t;

    // One query point.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
        logic signed [COORD_BITS-1:0] query_z;
    } query_t;

    // One result.
    typedef struct packed {
        logic [DIST_BITS-1:0]         distance;
        logic signed [COORD_BITS-1:0] near_x;
        logic signed [COORD_BITS-1:0] near_y;
        logic signed [COORD_BITS-1:0] near_z;
        where_t                       where_found;
    } result_t;

endpackage

// File: rtl/point_to_segment_distance.sv
// Top level of the pipelined point-to-segment distance block.
// Usage: each transfer on the s_ channel carries one query point P in signed Q16.16; one
// result per query leaves on the m_ channel in order: the nearest point of segment A-B,
// its rounded Euclidean distance and a location code. One query is taken every cycle
// unless the output stalls; most stages are the one-bit-per-stage restoring divider for
// the interior point and square root for the distance (COORD_BITS+1 stages each). The
// whole pipeline holds while a result waits on m_ready. The user must write endpoints
// over the cfg_ port only while the block is idle; this is not enforced by the block.
module point_to_segment_distance (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  ptsd_pkg::query_t                        s_data,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output ptsd_pkg::result_t                       m_data,
    input  logic                                    cfg_we,
    input  logic [ptsd_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [ptsd_pkg::COORD_BITS-1:0]         cfg_wdata
);

    localparam int N    = ptsd_pkg::COORD_BITS;
    localparam int EW   = N + 1;          // coordinate difference
    localparam int PW   = 2 * EW;         // product of two differences
    localparam int DW   = 2 * N + 4;      // dot product, signed
    localparam int LW   = 2 * N + 2;      // squared length, unsigned
    localparam int NW   = EW + LW;        // division numerator
    localparam int QW   = N + 1;          // quotient bits
    localparam int SW   = 2 * N + 2;      // squared distance
    localparam int RW   = N + 1;          // root bits
    localparam int FRONT = 6;
    localparam int DIV0  = FRONT;
    localparam int RND   = DIV0 + QW;
    localparam int NEAR  = RND + 1;
    localparam int SQ    = NEAR + 1;
    localparam int SUM   = SQ + 1;
    localparam int SQR0  = SUM + 1;
    localparam int NSTG  = SQR0 + RW + 1;

    typedef logic [2:0][N-1:0]  coord3_t;
    typedef logic [2:0][EW-1:0] diff3_t;

    // Context carried through the divider.
    typedef struct packed {
        coord3_t           p;
        coord3_t           a;
        coord3_t           base;
        logic [2:0]        dneg;
        ptsd_pkg::where_t  code;
        logic [LW-1:0]     l2;
    } dctx_t;

    typedef struct packed {
        logic [2:0][NW-1:0] rem;
        logic [2:0][QW-1:0] q;
    } dnum_t;

    typedef struct packed {
        coord3_t           near;
        ptsd_pkg::where_t  code;
    } sctx_t;

    typedef struct packed {
        logic [SW-1:0] rem;
        logic [RW-1:0] r;
    } sroot_t;

    logic en;
    logic [NSTG-1:0] v_reg;

    // Endpoint registers.
    coord3_t a_cfg_reg, b_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_cfg_reg <= '0;
            b_cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                ptsd_pkg::CFG_END_A_X: a_cfg_reg[0] <= cfg_wdata;
                ptsd_pkg::CFG_END_A_Y: a_cfg_reg[1] <= cfg_wdata;
                ptsd_pkg::CFG_END_A_Z: a_cfg_reg[2] <= cfg_wdata;
                ptsd_pkg::CFG_END_B_X: b_cfg_reg[0] <= cfg_wdata;
                ptsd_pkg::CFG_END_B_Y: b_cfg_reg[1] <= cfg_wdata;
                ptsd_pkg::CFG_END_B_Z: b_cfg_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Global pipeline enable: everything moves unless a result is stuck at the output.
    assign en      = !v_reg[NSTG-1] || m_ready;
    assign s_ready = en;
    assign m_valid = v_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NSTG-2:0], s_valid};
        end
    end

    // Stage 1: differences P-A and B-A.
    coord3_t p_in, p1_reg, a1_reg, b1_reg;
    diff3_t  e1_reg, d1_reg;

    assign p_in = {s_data.query_z, s_data.query_y, s_data.query_x};

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= {p_in[i][N-1], p_in[i]} - {a_cfg_reg[i][N-1], a_cfg_reg[i]};
                d1_reg[i] <= {b_cfg_reg[i][N-1], b_cfg_reg[i]} - {a_cfg_reg[i][N-1], a_cfg_reg[i]};
            end
            p1_reg <= p_in;
            a1_reg <= a_cfg_reg;
            b1_reg <= b_cfg_reg;
        end
    end

    // Stage 2: per-axis products for the dot product and the squared length.
    logic [2:0][PW-1:0] pe2_reg, pd2_reg;
    coord3_t p2_reg, a2_reg, b2_reg;
    diff3_t  d2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pe2_reg[i] <= PW'($signed(e1_reg[i])) * PW'($signed(d1_reg[i]));
                pd2_reg[i] <= PW'($signed(d1_reg[i])) * PW'($signed(d1_reg[i]));
            end
            p2_reg <= p1_reg;
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
            d2_reg <= d1_reg;
        end
    end

    // Stage 3: sum the three axes.
    logic [DW-1:0] dot3_reg;
    logic [LW-1:0] l23_reg;
    coord3_t p3_reg, a3_reg, b3_reg;
    diff3_t  d3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dot3_reg <= {{(DW-PW){pe2_reg[0][PW-1]}}, pe2_reg[0]}
                      + {{(DW-PW){pe2_reg[1][PW-1]}}, pe2_reg[1]}
                      + {{(DW-PW){pe2_reg[2][PW-1]}}, pe2_reg[2]};
            l23_reg  <= LW'(pd2_reg[0]) + LW'(pd2_reg[1]) + LW'(pd2_reg[2]);
            p3_reg <= p2_reg;
            a3_reg <= a2_reg;
            b3_reg <= b2_reg;
            d3_reg <= d2_reg;
        end
    end

    // Stage 4: classify the projection and pick the end point used outside the interior.
    logic dot_neg, dot_ge;
    ptsd_pkg::where_t code4;
    dctx_t c4_reg;
    logic [LW-1:0] dotm4_reg;
    diff3_t dmag4_reg;

    assign dot_neg = dot3_reg[DW-1];
    assign dot_ge  = !dot_neg && (dot3_reg[DW-2:0] >= {1'b0, l23_reg});

    always_comb begin
        if (l23_reg == '0) begin
            code4 = ptsd_pkg::WHERE_DEGEN;
        end else if (dot_neg) begin
            code4 = ptsd_pkg::WHERE_END_A;
        end else if (dot_ge) begin
            code4 = ptsd_pkg::WHERE_END_B;
        end else begin
            code4 = ptsd_pkg::WHERE_INTERIOR;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                c4_reg.dneg[i] <= d3_reg[i][EW-1];
                dmag4_reg[i]   <= d3_reg[i][EW-1] ? (EW'(0) - d3_reg[i]) : d3_reg[i];
            end
            c4_reg.p    <= p3_reg;
            c4_reg.a    <= a3_reg;
            c4_reg.base <= (code4 == ptsd_pkg::WHERE_END_B) ? b3_reg : a3_reg;
            c4_reg.code <= code4;
            c4_reg.l2   <= l23_reg;
            dotm4_reg   <= dot3_reg[LW-1:0];
        end
    end

    // Stage 5: |d_i| * dot as two partial products.
    logic [2:0][PW-1:0] pplo5_reg, pphi5_reg;
    dctx_t c5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pplo5_reg[i] <= PW'(dmag4_reg[i]) * PW'(dotm4_reg[EW-1:0]);
                pphi5_reg[i] <= PW'(dmag4_reg[i]) * PW'(dotm4_reg[LW-1:EW]);
            end
            c5_reg <= c4_reg;
        end
    end

    // Stage 6: assemble the numerators.
    dnum_t n6_reg;
    dctx_t c6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                n6_reg.rem[i] <= NW'(pplo5_reg[i]) + (NW'(pphi5_reg[i]) << EW);
            end
            n6_reg.q <= '0;
            c6_reg   <= c5_reg;
        end
    end

    // Restoring divider, one quotient bit per stage, three lanes.
    dnum_t dn_reg [QW];
    dctx_t dc_reg [QW];
    dnum_t dn_in  [QW];
    dctx_t dc_in  [QW];

    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int K = QW - 1 - j;
        logic [NW-1:0] trial;

        if (j == 0) begin : g_first
            assign dn_in[j] = n6_reg;
            assign dc_in[j] = c6_reg;
        end else begin : g_next
            assign dn_in[j] = dn_reg[j-1];
            assign dc_in[j] = dc_reg[j-1];
        end

        assign trial = NW'(dc_in[j].l2) << K;

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    if (dn_in[j].rem[i] >= trial) begin
                        dn_reg[j].rem[i] <= dn_in[j].rem[i] - trial;
                        dn_reg[j].q[i]   <= dn_in[j].q[i] | (QW'(1) << K);
                    end else begin
                        dn_reg[j].rem[i] <= dn_in[j].rem[i];
                        dn_reg[j].q[i]   <= dn_in[j].q[i];
                    end
                end
                dc_reg[j] <= dc_in[j];
            end
        end
    end

    // Round the quotients to nearest, halves away from zero.
    logic [2:0][QW-1:0] qr_reg;
    dctx_t cr_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                qr_reg[i] <= dn_reg[QW-1].q[i]
                    + QW'({dn_reg[QW-1].rem[i][LW-1:0], 1'b0} >= {1'b0, dc_reg[QW-1].l2});
            end
            cr_reg <= dc_reg[QW-1];
        end
    end

    // Nearest point.
    sctx_t cn_reg;
    coord3_t pn_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (cr_reg.code == ptsd_pkg::WHERE_INTERIOR) begin
                    cn_reg.near[i] <= cr_reg.dneg[i] ? (cr_reg.a[i] - N'(qr_reg[i]))
                                                     : (cr_reg.a[i] + N'(qr_reg[i]));
                end else begin
                    cn_reg.near[i] <= cr_reg.base[i];
                end
            end
            cn_reg.code <= cr_reg.code;
            pn_reg      <= cr_reg.p;
        end
    end

    // Squared per-axis distance.
    logic [2:0][PW-1:0] sq_reg;
    sctx_t cq_reg;
    diff3_t diff;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = {pn_reg[i][N-1], pn_reg[i]} - {cn_reg.near[i][N-1], cn_reg.near[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= PW'($signed(diff[i])) * PW'($signed(diff[i]));
            end
            cq_reg <= cn_reg;
        end
    end

    // Sum of squares.
    sroot_t ss_reg;
    sctx_t cs_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ss_reg.rem <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            ss_reg.r   <= '0;
            cs_reg     <= cq_reg;
        end
    end

    // Digit-by-digit square root, one root bit per stage.
    sroot_t sr_reg [RW];
    sctx_t  sc_reg [RW];
    sroot_t sr_in  [RW];
    sctx_t  sc_in  [RW];

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        localparam int K = RW - 1 - j;
        logic [SW-1:0] trial;

        if (j == 0) begin : g_first
            assign sr_in[j] = ss_reg;
            assign sc_in[j] = cs_reg;
        end else begin : g_next
            assign sr_in[j] = sr_reg[j-1];
            assign sc_in[j] = sc_reg[j-1];
        end

        assign trial = (SW'(sr_in[j].r) << (K + 1)) | (SW'(1) << (2 * K));

        always_ff @(posedge aclk) begin
            if (en) begin
                if (sr_in[j].rem >= trial) begin
                    sr_reg[j].rem <= sr_in[j].rem - trial;
                    sr_reg[j].r   <= sr_in[j].r | (RW'(1) << K);
                end else begin
                    sr_reg[j] <= sr_in[j];
                end
                sc_reg[j] <= sc_in[j];
            end
        end
    end

    // Output register: round the root and present the result.
    ptsd_pkg::result_t out_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.distance <= sr_reg[RW-1].r
                + RW'(sr_reg[RW-1].rem > SW'(sr_reg[RW-1].r));
            out_reg.near_x      <= sc_reg[RW-1].near[0];
            out_reg.near_y      <= sc_reg[RW-1].near[1];
            out_reg.near_z      <= sc_reg[RW-1].near[2];
            out_reg.where_found <= sc_reg[RW-1].code;
        end
    end

    assign m_data = out_reg;

    // A result at the second end carries endpoint B.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.where_found == ptsd_pkg::WHERE_END_B |->
            m_data.near_x == b_cfg_reg[0] && m_data.near_y == b_cfg_reg[1]
            && m_data.near_z == b_cfg_reg[2])
        else $error("second-end result does not match endpoint B");

    // A result at the first end, or for a degenerate segment, carries endpoint A.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.where_found == ptsd_pkg::WHERE_END_A
                    || m_data.where_found == ptsd_pkg::WHERE_DEGEN) |->
            m_data.near_x == a_cfg_reg[0] && m_data.near_y == a_cfg_reg[1]
            && m_data.near_z == a_cfg_reg[2])
        else $error("first-end result does not match endpoint A");

    // Reset empties the pipeline.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the point-to-segment distance block.
module tb_top;

    localparam int Q1 = 65536;
    localparam logic signed [31:0] CMAX = 32'sh7fffffff;
    localparam logic signed [31:0] CMIN = 32'sh80000000;
    localparam int SETTLE_CYCLES = 90;
    localparam int HOLD_CYCLES = 300;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    ptsd_pkg::query_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ptsd_pkg::result_t m_data;
    logic cfg_we = 1'b0;
    logic [ptsd_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [ptsd_pkg::COORD_BITS-1:0] cfg_wdata = '0;

    // Local copy of the segment endpoints.
    logic signed [31:0] seg_a [3];
    logic signed [31:0] seg_b [3];

    ptsd_pkg::result_t pending_results [$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    typedef struct {
        int                seg;
        ptsd_pkg::query_t  q;
        bit                has_exp;
        ptsd_pkg::result_t exp;
    } dir_row_t;

    dir_row_t rows [$];

    point_to_segment_distance dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Exact nearest point, location code and rounded distance for one query.
    function automatic ptsd_pkg::result_t nearest_on_segment(ptsd_pkg::query_t q);
        logic signed [127:0] av [3];
        logic signed [127:0] bv [3];
        logic signed [127:0] pv [3];
        logic signed [127:0] dv [3];
        logic signed [127:0] nv [3];
        logic signed [127:0] dot, l2, num, quo, diff;
        logic [127:0] sq, root, cand;
        ptsd_pkg::result_t r;
        pv[0] = q.query_x;
        pv[1] = q.query_y;
        pv[2] = q.query_z;
        dot = 0;
        l2 = 0;
        for (int i = 0; i < 3; i++) begin
            av[i] = seg_a[i];
            bv[i] = seg_b[i];
            dv[i] = bv[i] - av[i];
            dot = dot + (pv[i] - av[i]) * dv[i];
            l2 = l2 + dv[i] * dv[i];
        end
        if (l2 == 0) begin
            r.where_found = ptsd_pkg::WHERE_DEGEN;
            nv = av;
        end else if (dot < 0) begin
            r.where_found = ptsd_pkg::WHERE_END_A;
            nv = av;
        end else if (dot >= l2) begin
            r.where_found = ptsd_pkg::WHERE_END_B;
            nv = bv;
        end else begin
            r.where_found = ptsd_pkg::WHERE_INTERIOR;
            for (int i = 0; i < 3; i++) begin
                num = (dv[i] < 0 ? -dv[i] : dv[i]) * dot;
                // Round half away from zero on the magnitude.
                quo = (2 * num + l2) / (2 * l2);
                nv[i] = av[i] + (dv[i] < 0 ? -quo : quo);
            end
        end
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            diff = pv[i] - nv[i];
            sq = sq + $unsigned(diff * diff);
        end
        // Bitwise floor square root, then round to nearest.
        root = 0;
        for (int b = 40; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= sq) root = cand;
        end
        if (sq - root * root > root) root = root + 1;
        r.distance = root[ptsd_pkg::DIST_BITS-1:0];
        r.near_x = nv[0][31:0];
        r.near_y = nv[1][31:0];
        r.near_z = nv[2][31:0];
        return r;
    endfunction

    function automatic dir_row_t mk_row(int seg, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, bit has_exp, logic [32:0] dist_val,
                                        logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                                        ptsd_pkg::where_t w);
        dir_row_t r;
        r.seg = seg;
        r.q = '{query_x: x, query_y: y, query_z: z};
        r.has_exp = has_exp;
        r.exp = '{distance: dist_val, near_x: nx, near_y: ny, near_z: nz, where_found: w};
        return r;
    endfunction

    // Wait until every expected result has arrived.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Write both endpoints while the block is idle.
    task automatic set_segment(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                               logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
        logic [31:0] vals [6];
        ptsd_pkg::cfg_idx_t idx;
        vals = '{ax, ay, az, bx, by, bz};
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        for (int i = 0; i < 6; i++) begin
            idx = ptsd_pkg::cfg_idx_t'(i);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= vals[i];
            if (i < 3) seg_a[i] = vals[i];
            else seg_b[i - 3] = vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // Offer one query and wait for its transfer.
    task automatic send_query(ptsd_pkg::query_t q, bit has_exp, ptsd_pkg::result_t exp);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data <= q;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(has_exp ? exp : nearest_on_segment(q));
    endtask

    function automatic ptsd_pkg::query_t random_query();
        ptsd_pkg::query_t q;
        longint pc [3];
        longint t;
        if ($urandom_range(0, 3) == 0) begin
            q = {$urandom, $urandom, $urandom};
        end else begin
            // A point near the segment, from a bit before A to a bit past B.
            t = longint'($urandom_range(0, 383)) - 64;
            for (int i = 0; i < 3; i++)
                pc[i] = longint'(seg_a[i])
                      + (((longint'(seg_b[i]) - longint'(seg_a[i])) * t) >>> 8)
                      + longint'($urandom_range(0, 2047)) - 1024;
            q = '{query_x: pc[0][31:0], query_y: pc[1][31:0], query_z: pc[2][31:0]};
        end
        return q;
    endfunction

    // Receiver: random stalls plus a requested long hold-off.
    always @(posedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", m_data);
            end else begin
                if (m_data !== pending_results[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", pending_results[0], m_data);
                end
                void'(pending_results.pop_front());
            end
        end
    end

    initial begin
        int cur_seg;
        logic [31:0] ra [3];
        logic [31:0] rb [3];
        for (int i = 0; i < 3; i++) begin
            seg_a[i] = '0;
            seg_b[i] = '0;
        end

        // Directed rows: zero segment after reset, an x-axis segment, extremes.
        rows.push_back(mk_row(0, 0, 0, 0, 1, 0, 0, 0, 0, ptsd_pkg::WHERE_DEGEN));
        rows.push_back(mk_row(0, Q1, 0, 0, 1, Q1, 0, 0, 0, ptsd_pkg::WHERE_DEGEN));
        rows.push_back(mk_row(0, 3 * Q1, 4 * Q1, 0, 1, 5 * Q1, 0, 0, 0,
                              ptsd_pkg::WHERE_DEGEN));
        rows.push_back(mk_row(0, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0, ptsd_pkg::WHERE_DEGEN));
        rows.push_back(mk_row(0, CMIN, CMIN, CMIN, 0, 0, 0, 0, 0, ptsd_pkg::WHERE_DEGEN));
        rows.push_back(mk_row(1, -Q1, 0, 0, 1, Q1, 0, 0, 0, ptsd_pkg::WHERE_END_A));
        rows.push_back(mk_row(1, 11 * Q1, 0, 0, 1, Q1, 10 * Q1, 0, 0,
                              ptsd_pkg::WHERE_END_B));
        rows.push_back(mk_row(1, 10 * Q1, 0, 0, 1, 0, 10 * Q1, 0, 0,
                              ptsd_pkg::WHERE_END_B));
        rows.push_back(mk_row(1, 0, Q1, 0, 1, Q1, 0, 0, 0, ptsd_pkg::WHERE_INTERIOR));
        rows.push_back(mk_row(1, 5 * Q1, Q1, 0, 1, Q1, 5 * Q1, 0, 0,
                              ptsd_pkg::WHERE_INTERIOR));
        rows.push_back(mk_row(1, 3, 7, -2, 0, 0, 0, 0, 0, ptsd_pkg::WHERE_INTERIOR));
        rows.push_back(mk_row(1, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0, ptsd_pkg::WHERE_INTERIOR));
        rows.push_back(mk_row(1, CMIN, CMIN, CMIN, 0, 0, 0, 0, 0, ptsd_pkg::WHERE_INTERIOR));
        rows.push_back(mk_row(2, 0, 0, 0, 0, 0, 0, 0, 0, ptsd_pkg::WHERE_INTERIOR));
        rows.push_back(mk_row(2, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0, ptsd_pkg::WHERE_INTERIOR));
        rows.push_back(mk_row(2, CMIN, CMIN, CMIN, 0, 0, 0, 0, 0, ptsd_pkg::WHERE_INTERIOR));
        rows.push_back(mk_row(2, CMAX, CMIN, 0, 0, 0, 0, 0, 0, ptsd_pkg::WHERE_INTERIOR));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        cur_seg = 0;
        foreach (rows[k]) begin
            if (rows[k].seg != cur_seg) begin
                cur_seg = rows[k].seg;
                if (cur_seg == 1) set_segment(0, 0, 0, 10 * Q1, 0, 0);
                else set_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
            end
            send_query(rows[k].q, rows[k].has_exp, rows[k].exp);
        end

        // Random phases, each with its own segment and idling mix.
        for (int ph = 0; ph < 6; ph++) begin
            for (int i = 0; i < 3; i++) begin
                ra[i] = $urandom;
                rb[i] = $urandom;
                if (ph == 1 || ph == 4) begin
                    ra[i] = $urandom_range(0, 2 * 1048576) - 1048576;
                    rb[i] = $urandom_range(0, 2 * 1048576) - 1048576;
                end
                if (ph == 2) rb[i] = ra[i];
                if (ph == 3) begin
                    ra[i] = CMAX;
                    rb[i] = CMIN;
                end
            end
            set_segment(ra[0], ra[1], ra[2], rb[0], rb[1], rb[2]);
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 66;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 66;
                end
                default: begin
                    send_idle_pct = 9;
                    recv_stall_pct = 9;
                end
            endcase
            for (int n = 0; n < 100; n++) begin
                // Long receiver hold-off so the pipeline fills and stalls the input.
                if (ph == 0 && n == 5) hold_requests++;
                send_query(random_query(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end

endmodule
